FILE: rtl/slfo_pkg.sv
`default_nettype none
package slfo_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_PHASE_INC = 2'd0;
	localparam logic [1:0] REG_INTERVAL  = 2'd1;
	localparam logic [1:0] REG_MIN_LEVEL = 2'd2;
	localparam logic [1:0] REG_MAX_LEVEL = 2'd3;

	localparam logic [31:0] PHASE_INC_RESET = 32'd0;
	localparam logic [8:0]  INTERVAL_RESET  = 9'd32;
	localparam logic [31:0] MIN_LEVEL_RESET = 32'd0;
	localparam logic [31:0] MAX_LEVEL_RESET = 32'd65536;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_HALF    = 64'd536870912;
	localparam logic [63:0] Q15_MAX     = 64'd32767;

	typedef logic [14:0] sine_mag_t;

	// Odd Taylor series of sine up to the x^13 term, argument and sum in Q2.30.
	function automatic sine_mag_t sine_q15(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] scaled;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + $signed(term);
		if (sum < 0) begin
			sum = 64'sd0;
		end
		scaled = ($unsigned(sum) * Q15_MAX + Q30_HALF) >> 30;
		if (scaled > Q15_MAX) begin
			scaled = Q15_MAX;
		end
		return scaled[14:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/sine_lfo_decimated.sv
// A level passes through the stage 1, stage 2 and output registers after its tick is taken.
// Throughput: one tick per cycle while tick_stall is low; the state read, update and
// write back of the state RAM completes every cycle through a forwarding register.
// A held output blocks the input only once both arithmetic stages behind it are full.
// Reset clears the oscillator state, the stage valid flags and the registers to their defaults.
`default_nettype none
module sine_lfo_decimated
	import slfo_pkg::*;
#(
	parameter int QUARTER_TABLE_DEPTH = 256,
	parameter int PHASE_BITS = 32,
	parameter int MAX_SEND_INTERVAL = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              tick_valid,
	output logic                   tick_stall,
	input  wire logic [11:0]       frame_offset,
	output logic                   level_valid,
	input  wire logic              level_stall,
	output logic      [11:0]       emit_position,
	output logic signed [31:0]     level
);

	localparam int CW = (MAX_SEND_INTERVAL > 2) ? $clog2(MAX_SEND_INTERVAL) : 1;
	localparam int KW = ((CW > 9) ? CW : 9) + 1;
	localparam int SW = PHASE_BITS + CW;
	localparam int IW = $clog2(4 * QUARTER_TABLE_DEPTH);
	localparam int TW = $clog2(QUARTER_TABLE_DEPTH + 1);
	localparam int MW = PHASE_BITS + IW;
	localparam logic [KW-1:0] MAX_IV = KW'(MAX_SEND_INTERVAL);
	localparam logic [MW-1:0] IDX_SCALE = MW'(4 * QUARTER_TABLE_DEPTH);
	localparam logic [IW-1:0] DEPTH_C = IW'(QUARTER_TABLE_DEPTH);

	// Configuration registers.
	logic [31:0] phase_inc_q;
	logic [8:0]  interval_q;
	logic [31:0] min_level_q;
	logic [31:0] max_level_q;

	logic cfg_write;
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= PHASE_INC_RESET;
			interval_q  <= INTERVAL_RESET;
			min_level_q <= MIN_LEVEL_RESET;
			max_level_q <= MAX_LEVEL_RESET;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_PHASE_INC: phase_inc_q <= pwdata;
				REG_INTERVAL:  interval_q  <= pwdata[8:0];
				REG_MIN_LEVEL: min_level_q <= pwdata;
				REG_MAX_LEVEL: max_level_q <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PHASE_INC: prdata = phase_inc_q;
			REG_INTERVAL:  prdata = {23'd0, interval_q};
			REG_MIN_LEVEL: prdata = min_level_q;
			REG_MAX_LEVEL: prdata = max_level_q;
		endcase
	end

	// Quarter-wave sine table, built at elaboration.
	sine_mag_t qtab [QUARTER_TABLE_DEPTH + 1];

	for (genvar k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin : g_tab
		localparam logic [63:0] X = (HALF_PI_Q30 * 64'(k)) / QUARTER_TABLE_DEPTH;
		assign qtab[k] = sine_q15(X);
	end

	// Pipeline control.
	logic v_s1, v_s2, hold_out, hold_s2, hold_s1, accept;

	assign hold_out   = level_valid && level_stall;
	assign hold_s2    = v_s2 && hold_out;
	assign hold_s1    = v_s1 && hold_s2;
	assign tick_stall = hold_s1;
	assign accept     = tick_valid && !tick_stall;

	// Oscillator state in a one-entry RAM, with the last write forwarded.
	logic [SW-1:0] st_rdata, st_wdata, fwd_q, st_cur;
	logic          wrote_q, st_valid_q;

	slfo_ram #(
		.WIDTH (SW),
		.DEPTH (1)
	) u_state (
		.clk   (clk),
		.we    (accept),
		.waddr (1'b0),
		.wdata (st_wdata),
		.raddr (1'b0),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrote_q    <= 1'b0;
			st_valid_q <= 1'b0;
		end else begin
			wrote_q <= accept;
			if (accept) begin
				st_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_q <= st_wdata;
		end
	end

	assign st_cur = wrote_q ? fwd_q : (st_valid_q ? st_rdata : '0);

	logic [PHASE_BITS-1:0] phase_cur, phase_nxt;
	logic [CW-1:0]         count_cur, count_nxt;
	logic [KW-1:0]         iv_eff, count_inc;
	logic                  emit;

	assign phase_cur = st_cur[SW-1:CW];
	assign count_cur = st_cur[CW-1:0];

	always_comb begin
		if (interval_q == 9'd0) begin
			iv_eff = KW'(1);
		end else if (KW'(interval_q) > MAX_IV) begin
			iv_eff = MAX_IV;
		end else begin
			iv_eff = KW'(interval_q);
		end
		count_inc = KW'(count_cur) + KW'(1);
		count_nxt = (count_inc >= iv_eff) ? '0 : count_inc[CW-1:0];
	end

	assign emit      = (count_cur == '0);
	assign phase_nxt = phase_cur + PHASE_BITS'({32'd0, phase_inc_q});
	assign st_wdata  = {phase_nxt, count_nxt};

	// Table lookup for the phase before this tick's advance.
	logic [MW-1:0]     idx_prod;
	logic [IW-1:0]     idx, rem;
	logic [1:0]        quad;
	logic [TW-1:0]     tidx;
	logic signed [15:0] sine;
	logic [15:0]       u_val;

	assign idx_prod = MW'(phase_cur) * IDX_SCALE;
	assign idx      = idx_prod[MW-1 -: IW];
	assign quad     = 2'(idx / QUARTER_TABLE_DEPTH);
	assign rem      = IW'(idx % QUARTER_TABLE_DEPTH);
	assign tidx     = quad[0] ? TW'({1'b0, DEPTH_C} - {1'b0, rem}) : TW'(rem);
	assign sine     = quad[1] ? -$signed({1'b0, qtab[tidx]}) : $signed({1'b0, qtab[tidx]});
	assign u_val    = sine ^ 16'sh8000;

	// Stage 1: offset sine; stage 2: product; output: round, add and saturate.
	logic [15:0] u_s1;
	logic [11:0] pos_s1, pos_s2;
	logic signed [49:0] p_s2;
	logic signed [32:0] span;

	assign span = $signed({max_level_q[31], max_level_q}) - $signed({min_level_q[31], min_level_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			level_valid <= 1'b0;
		end else begin
			if (!hold_s1) begin
				v_s1 <= accept && emit;
			end
			if (!hold_s2) begin
				v_s2 <= v_s1;
			end
			if (!hold_out) begin
				level_valid <= v_s2;
			end
		end
	end

	logic signed [50:0] rnd_sum;
	logic signed [34:0] lv;

	assign rnd_sum = 51'(p_s2) + 51'sd32768;
	assign lv = 35'($signed(min_level_q)) + 35'(rnd_sum >>> 16);

	always_ff @(posedge clk) begin
		if (!hold_s1 && accept && emit) begin
			u_s1   <= u_val;
			pos_s1 <= frame_offset;
		end
		if (!hold_s2 && v_s1) begin
			p_s2   <= $signed({1'b0, u_s1}) * span;
			pos_s2 <= pos_s1;
		end
		if (!hold_out && v_s2) begin
			emit_position <= pos_s2;
			if (lv > 35'sd2147483647) begin
				level <= 32'sh7fffffff;
			end else if (lv < -35'sd2147483648) begin
				level <= 32'sh80000000;
			end else begin
				level <= lv[31:0];
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/slfo_ram.sv
`default_nettype none
module slfo_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 1,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: tb/sine_lfo_checker.sv
`timescale 1ns / 1ps
module sine_lfo_level_checker
	import slfo_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	input  wire logic              tick_valid,
	input  wire logic              tick_stall,
	input  wire logic [11:0]       frame_offset,
	input  wire logic              level_valid,
	input  wire logic              level_stall,
	input  wire logic [11:0]       emit_position,
	input  wire logic signed [31:0] level,
	output int                     mismatches,
	output int                     backlog,
	output int                     ticks_seen,
	output int                     levels_seen
);

	localparam int TAB_DEPTH = 256;
	localparam int INTERVAL_CAP = 256;

	typedef struct packed {
		logic [11:0]        pos;
		logic signed [31:0] lvl;
	} level_beat_t;

	level_beat_t level_q[$];
	int          sine_tab[0:TAB_DEPTH];

	logic [31:0]        phase_inc;
	logic [8:0]         interval;
	logic signed [31:0] lo_level;
	logic signed [31:0] hi_level;
	logic [31:0]        phase_acc;
	int                 tick_count;

	function automatic int quarter_sine(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned scaled;
		longint          acc;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		scaled = (longint'(acc) * 64'd32767 + 64'd536870912) >> 30;
		if (scaled > 64'd32767) begin
			scaled = 64'd32767;
		end
		return int'(scaled);
	endfunction

	function automatic logic signed [31:0] predict_level(input logic [31:0] ph,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		logic [9:0] idx;
		logic [7:0] r;
		longint     s;
		longint     prod;
		longint     lv;
		idx = ph[31:22];
		r = idx[7:0];
		case (idx[9:8])
			2'd0: s = sine_tab[r];
			2'd1: s = sine_tab[TAB_DEPTH - r];
			2'd2: s = -sine_tab[r];
			default: s = -sine_tab[TAB_DEPTH - r];
		endcase
		prod = (s + 32768) * (longint'(hi) - longint'(lo));
		lv = longint'(lo) + ((prod + 32768) >>> 16);
		if (lv > 64'sd2147483647) begin
			lv = 64'sd2147483647;
		end
		if (lv < -64'sd2147483648) begin
			lv = -64'sd2147483648;
		end
		return lv[31:0];
	endfunction

	initial begin
		for (int k = 0; k <= TAB_DEPTH; k++) begin
			sine_tab[k] = quarter_sine((HALF_PI_Q30 * k) / TAB_DEPTH);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		level_beat_t want;
		int          lim;
		if (!arst_n) begin
			phase_inc = PHASE_INC_RESET;
			interval = INTERVAL_RESET;
			lo_level = MIN_LEVEL_RESET;
			hi_level = MAX_LEVEL_RESET;
			phase_acc = '0;
			tick_count = 0;
			level_q.delete();
			backlog = 0;
			mismatches = 0;
			ticks_seen = 0;
			levels_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PHASE_INC: phase_inc = pwdata;
					REG_INTERVAL:  interval = pwdata[8:0];
					REG_MIN_LEVEL: lo_level = pwdata;
					REG_MAX_LEVEL: hi_level = pwdata;
					default: ;
				endcase
			end
			if (level_valid && !level_stall) begin
				levels_seen++;
				if (level_q.size() == 0) begin
					mismatches++;
					$display("%0t: level beat with nothing expected: position %0d level %0d",
						$time, emit_position, level);
				end else begin
					want = level_q.pop_front();
					if (emit_position !== want.pos) begin
						mismatches++;
						$display("%0t: emit_position expected %0d got %0d",
							$time, want.pos, emit_position);
					end
					if (level !== want.lvl) begin
						mismatches++;
						$display("%0t: level expected %0d got %0d", $time, want.lvl, level);
					end
				end
			end
			if (tick_valid && !tick_stall) begin
				ticks_seen++;
				lim = (interval == 0) ? 1 : ((interval > INTERVAL_CAP) ? INTERVAL_CAP : interval);
				if (tick_count == 0) begin
					want.pos = frame_offset;
					want.lvl = predict_level(phase_acc, lo_level, hi_level);
					level_q.push_back(want);
				end
				tick_count++;
				if (tick_count >= lim) begin
					tick_count = 0;
				end
				phase_acc = phase_acc + phase_inc;
			end
			backlog = level_q.size();
		end
	end

endmodule

FILE: tb/sine_lfo_decimated_tb.sv
`timescale 1ns / 1ps
module sine_lfo_decimated_tb;
	import slfo_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              tick_valid = 1'b0;
	logic              tick_stall;
	logic [11:0]       frame_offset = '0;
	logic              level_valid;
	logic              level_stall = 1'b0;
	logic [11:0]       emit_position;
	logic signed [31:0] level;

	int mismatches;
	int backlog;
	int ticks_seen;
	int levels_seen;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int settings = 0;

	sine_lfo_decimated dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.tick_valid(tick_valid), .tick_stall(tick_stall), .frame_offset(frame_offset),
		.level_valid(level_valid), .level_stall(level_stall),
		.emit_position(emit_position), .level(level)
	);

	sine_lfo_level_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.tick_valid(tick_valid), .tick_stall(tick_stall), .frame_offset(frame_offset),
		.level_valid(level_valid), .level_stall(level_stall),
		.emit_position(emit_position), .level(level),
		.mismatches(mismatches), .backlog(backlog),
		.ticks_seen(ticks_seen), .levels_seen(levels_seen)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(4, 40);
		end
		stall_left--;
		case (stall_mode)
			0: level_stall = 1'b0;
			1: level_stall = 1'($urandom_range(0, 1));
			2: level_stall = ($urandom_range(0, 3) != 0);
			default: level_stall = ((stall_left % 8) < 3);
		endcase
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic configure(input logic [31:0] inc, input logic [8:0] intv,
			input logic [31:0] lo, input logic [31:0] hi);
		write_reg(REG_PHASE_INC, inc);
		write_reg(REG_INTERVAL, {23'd0, intv});
		write_reg(REG_MIN_LEVEL, lo);
		write_reg(REG_MAX_LEVEL, hi);
		settings++;
	endtask

	task automatic send_tick(input logic [11:0] pos);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				tick_valid = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		tick_valid = 1'b1;
		frame_offset = pos;
		do begin
			@(posedge clk);
		end while (tick_stall);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic settle();
		tick_valid = 1'b0;
		wait (backlog == 0);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_level();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [31:0] inc;
		logic [8:0]  intv;
		int          n;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_tick(12'd0);
		send_tick(12'hfff);
		send_tick(12'($urandom_range(0, 4095)));
		settle();
		configure(32'h4000_0000, 9'd0, 32'h8000_0000, 32'h7fff_ffff);
		repeat (5) send_tick(12'($urandom_range(0, 4095)));
		settle();
		configure(32'h8000_0000, 9'd511, 32'h7fff_ffff, 32'h8000_0000);
		repeat (4) send_tick(12'($urandom_range(0, 4095)));
		settle();
		configure(32'hffff_ffff, 9'd2, 32'hffff_0000, 32'h0001_8000);
		repeat (3) send_tick(12'($urandom_range(0, 4095)));
		settle();
		configure(32'd1, 9'd1, 32'd12345, 32'd12345);
		send_tick(12'hfff);
		send_tick(12'd0);
		send_tick(12'ha5a);
		settle();

		while (ticks_seen < 620) begin
			case ($urandom_range(0, 4))
				0: inc = 32'd0;
				1: inc = 32'h8000_0000;
				2: inc = $urandom_range(0, 32'h0010_0000);
				default: inc = $urandom;
			endcase
			case ($urandom_range(0, 9))
				0: intv = 9'd0;
				1: intv = 9'($urandom_range(7, 511));
				default: intv = 9'($urandom_range(1, 6));
			endcase
			configure(inc, intv, pick_level(), pick_level());
			n = $urandom_range(20, 60);
			repeat (n) send_tick(12'($urandom_range(0, 4095)));
			settle();
		end

		repeat (20) @(negedge clk);
		$display("Run covered %0d ticks over %0d register settings, with %0d levels checked.",
			ticks_seen, settings, levels_seen);
		if (mismatches == 0 && backlog == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
